// ===== design/kccd_pkg.sv =====
package kccd_pkg;

    localparam int NUM_PATTERNS = 8;
    localparam int MAX_KEYS     = 16;
    localparam int KEY_CODES    = 64;

    localparam int SLOT_W = 3;
    localparam int POS_W  = 4;
    localparam int CODE_W = 6;
    localparam int LEN_W  = 5;
    localparam int WIN_W  = 16;
    localparam int MAP_W  = 64;
    localparam int CNT_W  = 32;

    localparam logic [WIN_W-1:0] DEFAULT_WINDOW = WIN_W'(15);
    localparam logic [CNT_W-1:0] CNT_MAX        = '1;

    typedef enum logic [1:0] {
        MODE_FRAME = 2'd0,
        MODE_KEY   = 2'd1,
        MODE_HDR   = 2'd2
    } mode_t;

    // frame data handed from cell to cell
    typedef struct packed {
        logic             tok;
        logic             wrap;
        logic [CNT_W-1:0] fc;
        logic [MAP_W-1:0] held;
        logic [MAP_W-1:0] pressed;
    } link_t;

    // key / header write broadcast to all cells
    typedef struct packed {
        logic              key_we;
        logic              hdr_we;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  pos;
        logic [CODE_W-1:0] code;
        logic              kind;
        logic [LEN_W-1:0]  len;
        logic [WIN_W-1:0]  win;
    } wr_t;

    // one slot report from a cell
    typedef struct packed {
        logic              vld;
        logic [SLOT_W-1:0] slot;
        logic              trig;
        logic              act;
        logic [LEN_W-1:0]  prog;
        logic              last;
    } report_t;

    function automatic logic key_bit(input logic [MAP_W-1:0] map, input logic [CODE_W-1:0] code);
        key_bit = (int'(code) < KEY_CODES) ? map[code] : 1'b0;
    endfunction

endpackage

// ===== design/kccd_cell.sv =====
module kccd_cell import kccd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [SLOT_W-1:0] cell_idx,
    input  logic              adv,
    input  wr_t               wr,
    input  link_t             link_in,
    output link_t             link_out,
    output report_t           rep
);

    logic [CODE_W-1:0] keys_reg [MAX_KEYS];

    logic              kind_reg,     kind_next;
    logic [LEN_W-1:0]  len_reg,      len_next;
    logic [WIN_W-1:0]  win_reg,      win_next;
    logic              was_held_reg, was_held_next;
    logic              is_held_reg,  is_held_next;
    logic [POS_W-1:0]  pos_reg,      pos_next;
    logic [CNT_W-1:0]  lmt_reg,      lmt_next;
    logic              tok_reg,      tok_next;
    link_t             data_reg;

    logic              sel, eval;
    logic [POS_W-1:0]  p0, p1;
    logic [CNT_W-1:0]  lmt0, elapsed;
    logic              in_pat  [MAX_KEYS];
    logic              hb      [MAX_KEYS];
    logic              pb      [MAX_KEYS];
    logic              chord_full, any_press, wrong, exp_hit;
    logic [CODE_W-1:0] expect_code;
    logic [LEN_W-1:0]  p_inc;
    logic              trig, act;
    logic [LEN_W-1:0]  prog;

    assign sel  = (wr.slot == cell_idx);
    assign eval = link_in.tok & adv;

    // a counter wrap clears combo progress before evaluation
    assign p0   = link_in.wrap ? '0 : pos_reg;
    assign lmt0 = link_in.wrap ? '0 : lmt_reg;

    assign elapsed = (link_in.fc >= lmt0) ? (link_in.fc - lmt0) : CNT_MAX;
    assign p1      = ((p0 != '0) && (elapsed > CNT_W'(win_reg))) ? '0 : p0;
    assign expect_code = keys_reg[p1];
    assign exp_hit     = key_bit(link_in.pressed, expect_code);
    assign p_inc       = LEN_W'({1'b0, p1}) + LEN_W'(1);

    always_comb begin
        chord_full = 1'b1;
        any_press  = 1'b0;
        wrong      = 1'b0;
        for (int k = 0; k < MAX_KEYS; k++) begin
            in_pat[k]  = (LEN_W'(k) < len_reg);
            hb[k]      = key_bit(link_in.held, keys_reg[k]);
            pb[k]      = key_bit(link_in.pressed, keys_reg[k]);
            chord_full = chord_full & (~in_pat[k] | hb[k]);
            any_press  = any_press | (in_pat[k] & pb[k]);
            wrong      = wrong | (in_pat[k] & pb[k] & (keys_reg[k] != expect_code));
        end
    end

    always_comb begin
        kind_next     = kind_reg;
        len_next      = len_reg;
        win_next      = win_reg;
        was_held_next = was_held_reg;
        is_held_next  = is_held_reg;
        pos_next      = pos_reg;
        lmt_next      = lmt_reg;
        tok_next      = adv ? link_in.tok : tok_reg;
        trig          = 1'b0;
        act           = 1'b0;
        prog          = '0;

        if (wr.hdr_we && sel && (int'(wr.len) <= MAX_KEYS)) begin
            was_held_next = 1'b0;
            is_held_next  = 1'b0;
            pos_next      = '0;
            lmt_next      = '0;
            len_next      = wr.len;
            if (wr.len == '0) begin
                kind_next = 1'b0;
                win_next  = '0;
            end else begin
                kind_next = wr.kind;
                if (wr.kind) begin
                    win_next = (wr.win == '0) ? DEFAULT_WINDOW : wr.win;
                end else begin
                    win_next = '0;
                end
            end
        end else if (eval) begin
            pos_next = p0;
            lmt_next = lmt0;
            if (len_reg != '0 && !kind_reg) begin
                // chord
                was_held_next = is_held_reg;
                is_held_next  = chord_full;
                trig          = chord_full & ~is_held_reg & any_press;
                act           = chord_full;
                prog          = chord_full ? len_reg : '0;
            end else if (len_reg != '0) begin
                // timed combo
                was_held_next = is_held_reg;
                is_held_next  = 1'b0;
                pos_next      = p1;
                if (LEN_W'({1'b0, p1}) < len_reg) begin
                    if (wrong) begin
                        pos_next = '0;
                    end else if (exp_hit) begin
                        lmt_next = link_in.fc;
                        if (p_inc >= len_reg) begin
                            trig         = 1'b1;
                            is_held_next = 1'b1;
                            pos_next     = '0;
                        end else begin
                            pos_next = p_inc[POS_W-1:0];
                        end
                    end
                end else begin
                    pos_next = '0;
                end
                act  = is_held_next;
                prog = LEN_W'({1'b0, pos_next});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg     <= 1'b0;
            len_reg      <= '0;
            win_reg      <= '0;
            was_held_reg <= 1'b0;
            is_held_reg  <= 1'b0;
            pos_reg      <= '0;
            lmt_reg      <= '0;
            tok_reg      <= 1'b0;
        end else begin
            kind_reg     <= kind_next;
            len_reg      <= len_next;
            win_reg      <= win_next;
            was_held_reg <= was_held_next;
            is_held_reg  <= is_held_next;
            pos_reg      <= pos_next;
            lmt_reg      <= lmt_next;
            tok_reg      <= tok_next;
        end
    end

    // key codes: undefined until written
    always_ff @(posedge aclk) begin
        if (wr.key_we && sel) begin
            keys_reg[wr.pos] <= wr.code;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= link_in;
        end
    end

    always_comb begin
        link_out     = data_reg;
        link_out.tok = tok_reg;
    end

    assign rep.vld  = eval;
    assign rep.slot = cell_idx;
    assign rep.trig = trig;
    assign rep.act  = act;
    assign rep.prog = prog;
    assign rep.last = (int'(cell_idx) == NUM_PATTERNS - 1);

endmodule

// ===== design/key_chord_combo_detector.sv =====
// Output: the frame is registered at the head of the cell row and each slot report in the
// output register; one report per cycle while m_ready is high (8 reports, slot 0 first).
// Flow: no frame, key or header item is taken while a frame is in the row of slot cells;
// the frame walks the row one cell a cycle while the output register can take a report.
// Reset: aresetn is synchronous, active low; all slots empty, frame counter 0.
// Pattern key codes are not cleared by reset.
module key_chord_combo_detector import kccd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_mode,
    input  logic [SLOT_W-1:0] s_slot,
    input  logic [POS_W-1:0]  s_key_position,
    input  logic [CODE_W-1:0] s_key_code,
    input  logic              s_pattern_kind,
    input  logic [LEN_W-1:0]  s_pattern_length,
    input  logic [WIN_W-1:0]  s_window,
    input  logic [MAP_W-1:0]  s_held_keys,
    input  logic [MAP_W-1:0]  s_pressed_keys,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [SLOT_W-1:0] m_result_slot,
    output logic              m_triggered,
    output logic              m_active,
    output logic [LEN_W-1:0]  m_progress,
    output logic              m_last
);

    // links[i] feeds cell i; links[NUM_PATTERNS] is the token leaving the last cell
    link_t   links [NUM_PATTERNS+1];
    report_t reps  [NUM_PATTERNS];
    report_t rep_sel;
    wr_t     wr;

    logic             busy, accept, accept_frame, adv;
    logic [CNT_W-1:0] fc_reg, fc_next;
    logic             tok0_reg, tok0_next;
    link_t            head_reg;

    logic              m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0] slot_reg;
    logic              trig_reg, act_reg, last_reg;
    logic [LEN_W-1:0]  prog_reg;

    // a frame is in flight while any token sits in the chain
    always_comb begin
        busy = 1'b0;
        for (int i = 0; i <= NUM_PATTERNS; i++) begin
            busy = busy | links[i].tok;
        end
    end

    assign s_ready = ~busy;
    assign accept  = s_valid & s_ready;

    // the chain advances whenever the output register can take a report
    assign adv = ~m_valid_reg | m_ready;

    // decode of the accepted item
    always_comb begin
        accept_frame = 1'b0;
        wr.key_we    = 1'b0;
        wr.hdr_we    = 1'b0;
        case (s_mode)
            MODE_FRAME: accept_frame = accept;
            MODE_KEY:   wr.key_we    = accept;
            MODE_HDR:   wr.hdr_we    = accept;
            default:    ;
        endcase
        wr.slot = s_slot;
        wr.pos  = s_key_position;
        wr.code = s_key_code;
        wr.kind = s_pattern_kind;
        wr.len  = s_pattern_length;
        wr.win  = s_window;
    end

    // frame counter: at its maximum it restarts at 1 and flags a wrap to the cells
    assign fc_next = (fc_reg == CNT_MAX) ? CNT_W'(1) : fc_reg + CNT_W'(1);

    always_comb begin
        tok0_next = tok0_reg;
        if (accept_frame) begin
            tok0_next = 1'b1;
        end else if (adv) begin
            tok0_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fc_reg   <= '0;
            tok0_reg <= 1'b0;
        end else begin
            tok0_reg <= tok0_next;
            if (accept_frame) begin
                fc_reg <= fc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_frame) begin
            head_reg.tok     <= 1'b1;
            head_reg.wrap    <= (fc_reg == CNT_MAX);
            head_reg.fc      <= fc_next;
            head_reg.held    <= s_held_keys;
            head_reg.pressed <= s_pressed_keys;
        end
    end

    always_comb begin
        links[0]     = head_reg;
        links[0].tok = tok0_reg;
    end

    // row of slot cells
    for (genvar g = 0; g < NUM_PATTERNS; g++) begin : g_cell
        kccd_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (SLOT_W'(g)),
            .adv      (adv),
            .wr       (wr),
            .link_in  (links[g]),
            .link_out (links[g+1]),
            .rep      (reps[g])
        );
    end

    // only the cell holding the token reports in a given cycle
    always_comb begin
        rep_sel = '0;
        for (int i = 0; i < NUM_PATTERNS; i++) begin
            if (reps[i].vld) begin
                rep_sel = reps[i];
            end
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (rep_sel.vld) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rep_sel.vld) begin
            slot_reg <= rep_sel.slot;
            trig_reg <= rep_sel.trig;
            act_reg  <= rep_sel.act;
            prog_reg <= rep_sel.prog;
            last_reg <= rep_sel.last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_slot = slot_reg;
    assign m_triggered   = trig_reg;
    assign m_active      = act_reg;
    assign m_progress    = prog_reg;
    assign m_last        = last_reg;

endmodule

// ===== design/kccd_checker.sv =====
module kccd_checker import kccd_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [SLOT_W-1:0] m_result_slot,
    input logic              m_triggered,
    input logic              m_active,
    input logic              m_last
);

    // no new item is taken while a frame's reports are still coming out
    a_busy_mid_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> !s_ready)
        else $error("item accepted in the middle of a frame report");

    a_last_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> (m_result_slot == SLOT_W'(NUM_PATTERNS - 1)))
        else $error("last flag on a report other than the final slot");

    a_trig_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_triggered) |-> m_active)
        else $error("pattern triggered without being active");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result_slot)))
        else $error("report dropped or changed while stalled");

endmodule

bind key_chord_combo_detector kccd_checker u_kccd_checker (.*);

// ===== verif/key_chord_combo_detector_test.sv =====
module key_chord_combo_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kccd_pkg::*;

    // Pattern kinds and the mode code the block ignores
    localparam logic       KIND_CHORD   = 1'b0;
    localparam logic       KIND_COMBO   = 1'b1;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 75;
    localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer on either side
    localparam int TAIL_CYCLES  = 24;    // frame walk plus margin after the last report
    localparam int PRINT_LIMIT  = 100;

    // One input item as driven on the s_ side
    typedef struct packed {
        logic [1:0]        mode;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  pos;
        logic [CODE_W-1:0] code;
        logic              kind;
        logic [LEN_W-1:0]  len;
        logic [WIN_W-1:0]  win;
        logic [MAP_W-1:0]  held;
        logic [MAP_W-1:0]  pressed;
        logic              drain_first;  // hold this item until all reports are in
    } item_t;

    // One slot report as seen on the m_ side
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              trig;
        logic              act;
        logic [LEN_W-1:0]  prog;
        logic              last;
    } slot_report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_mode = '0;
    logic [SLOT_W-1:0] s_slot = '0;
    logic [POS_W-1:0]  s_key_position = '0;
    logic [CODE_W-1:0] s_key_code = '0;
    logic              s_pattern_kind = 1'b0;
    logic [LEN_W-1:0]  s_pattern_length = '0;
    logic [WIN_W-1:0]  s_window = '0;
    logic [MAP_W-1:0]  s_held_keys = '0;
    logic [MAP_W-1:0]  s_pressed_keys = '0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [SLOT_W-1:0] m_result_slot;
    logic              m_triggered;
    logic              m_active;
    logic [LEN_W-1:0]  m_progress;
    logic              m_last;

    key_chord_combo_detector dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_slot           (s_slot),
        .s_key_position   (s_key_position),
        .s_key_code       (s_key_code),
        .s_pattern_kind   (s_pattern_kind),
        .s_pattern_length (s_pattern_length),
        .s_window         (s_window),
        .s_held_keys      (s_held_keys),
        .s_pressed_keys   (s_pressed_keys),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_slot    (m_result_slot),
        .m_triggered      (m_triggered),
        .m_active         (m_active),
        .m_progress       (m_progress),
        .m_last           (m_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted pattern state, kept in step with the accepted items
    // ------------------------------------------------------------------
    logic [CODE_W-1:0] pat_code    [NUM_PATTERNS][MAX_KEYS];
    logic              pat_kind    [NUM_PATTERNS];
    logic [LEN_W-1:0]  pat_len     [NUM_PATTERNS];
    logic [WIN_W-1:0]  pat_window  [NUM_PATTERNS];
    logic              chord_prev  [NUM_PATTERNS];  // held on the previous frame
    logic              chord_on    [NUM_PATTERNS];  // held now / combo fired now
    logic [3:0]        combo_step  [NUM_PATTERNS];
    logic [CNT_W-1:0]  combo_stamp [NUM_PATTERNS];  // frame of the last combo match
    logic [CNT_W-1:0]  frame_no = '0;

    slot_report_t pending_reports[$];
    item_t        queued_items[$];
    item_t        live_item;

    int  mismatches = 0;
    int  reports_seen = 0;
    int  quiet_cycles = 0;
    logic s_took = 1'b0;

    // Applies one accepted item; a frame tick queues one report per slot.
    task automatic detect_patterns(input item_t it);
        slot_report_t rep;
        int n, p, s, k;
        logic chord_full, any_press, wrong;
        logic [CODE_W-1:0] want_code, c;
        logic [CNT_W-1:0] span;
        case (it.mode)
            MODE_KEY: begin
                pat_code[it.slot][it.pos] = it.code;
            end
            MODE_HDR: begin
                // lengths past the key limit leave the slot untouched
                if (it.len <= MAX_KEYS) begin
                    chord_prev[it.slot]  = 1'b0;
                    chord_on[it.slot]    = 1'b0;
                    combo_step[it.slot]  = '0;
                    combo_stamp[it.slot] = '0;
                    pat_len[it.slot]     = it.len;
                    if (it.len == 0) begin
                        pat_kind[it.slot]   = KIND_CHORD;
                        pat_window[it.slot] = '0;
                    end else begin
                        pat_kind[it.slot] = it.kind;
                        if (it.kind == KIND_COMBO) begin
                            pat_window[it.slot] = (it.win == '0) ? DEFAULT_WINDOW : it.win;
                        end else begin
                            pat_window[it.slot] = '0;
                        end
                    end
                end
            end
            MODE_FRAME: begin
                // counter wrap restarts every combo
                if (frame_no == CNT_MAX) begin
                    frame_no = 1;
                    for (s = 0; s < NUM_PATTERNS; s++) begin
                        combo_step[s]  = '0;
                        combo_stamp[s] = '0;
                    end
                end else begin
                    frame_no = frame_no + 1;
                end
                for (s = 0; s < NUM_PATTERNS; s++) begin
                    n = pat_len[s];
                    rep = '0;
                    rep.slot = SLOT_W'(s);
                    rep.last = (s == NUM_PATTERNS - 1);
                    if (n > 0 && pat_kind[s] == KIND_CHORD) begin
                        chord_full = 1'b1;
                        any_press  = 1'b0;
                        for (k = 0; k < n; k++) begin
                            c = pat_code[s][k];
                            chord_full = chord_full & it.held[c];
                            any_press  = any_press | it.pressed[c];
                        end
                        chord_prev[s] = chord_on[s];
                        chord_on[s]   = chord_full;
                        // rising edge of the whole chord, caused by a press
                        rep.trig = chord_full && !chord_prev[s] && any_press;
                        rep.act  = chord_full;
                        rep.prog = chord_full ? LEN_W'(n) : '0;
                    end else if (n > 0) begin
                        p = combo_step[s];
                        wrong = 1'b0;
                        chord_prev[s] = chord_on[s];
                        chord_on[s]   = 1'b0;
                        if (p > 0) begin
                            span = (frame_no >= combo_stamp[s]) ? frame_no - combo_stamp[s]
                                                                : CNT_MAX;
                            if (span > CNT_W'(pat_window[s])) p = 0;  // timed out
                        end
                        if (p < n) begin
                            want_code = pat_code[s][p];
                            // any other member key pressed breaks the sequence
                            for (k = 0; k < n; k++) begin
                                c = pat_code[s][k];
                                if (c != want_code && it.pressed[c]) wrong = 1'b1;
                            end
                            if (wrong) begin
                                p = 0;
                            end else if (it.pressed[want_code]) begin
                                p++;
                                combo_stamp[s] = frame_no;
                                if (p >= n) begin
                                    rep.trig    = 1'b1;
                                    chord_on[s] = 1'b1;
                                    p = 0;
                                end
                            end
                        end else begin
                            p = 0;
                        end
                        combo_step[s] = 4'(p);
                        rep.act  = chord_on[s];
                        rep.prog = LEN_W'(combo_step[s]);
                    end
                    pending_reports.push_back(rep);
                end
            end
            default: ;  // unused mode: dropped
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("MISMATCH @%0d ns, report %0d: %s got %0d want %0d",
                     $time, reports_seen, what, got, want);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: both transfers are sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        slot_report_t want;
        if (aresetn) begin
            s_took <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (pending_reports.size() == 0) begin
                    report_mismatch("unexpected report for slot", m_result_slot, -1);
                end else begin
                    want = pending_reports.pop_front();
                    if (m_result_slot !== want.slot)
                        report_mismatch("result_slot", m_result_slot, want.slot);
                    if (m_triggered !== want.trig)
                        report_mismatch("triggered", m_triggered, want.trig);
                    if (m_active !== want.act)
                        report_mismatch("active", m_active, want.act);
                    if (m_progress !== want.prog)
                        report_mismatch("progress", m_progress, want.prog);
                    if (m_last !== want.last)
                        report_mismatch("last", m_last, want.last);
                end
                reports_seen++;
            end
            if (s_valid && s_ready) detect_patterns(live_item);
            // watchdog: counts cycles with no transfer at all
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: bursts with random gaps, changes at the falling edge
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left = 0;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_took) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (queued_items.size() > 0 &&
                             !(queued_items[0].drain_first && pending_reports.size() > 0)) begin
                    live_item = queued_items.pop_front();
                    s_mode           <= live_item.mode;
                    s_slot           <= live_item.slot;
                    s_key_position   <= live_item.pos;
                    s_key_code       <= live_item.code;
                    s_pattern_kind   <= live_item.kind;
                    s_pattern_length <= live_item.len;
                    s_window         <= live_item.win;
                    s_held_keys      <= live_item.held;
                    s_pressed_keys   <= live_item.pressed;
                    s_valid          <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        // now and then a long burst with no gap after it
                        if ($urandom_range(0, 3) == 0) begin
                            burst_left = 16;
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 6);
                            gap_left   = $urandom_range(1, 4);
                        end
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: phases picked by rx_tick[7:6] of full rate, ready on multiples of three
    // in rx_tick, coin toss, and long stalls with short ready windows.
    int unsigned rx_tick = 0;

    always @(negedge aclk) begin
        rx_tick++;
        case (rx_tick[7:6])
            2'd0:    m_ready <= 1'b1;
            2'd1:    m_ready <= (rx_tick % 3) == 0;
            2'd2:    m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= (rx_tick[2:0] >= 3'd6);
        endcase
    end

    // ------------------------------------------------------------------
    // Stimulus generation; the gen_* arrays track what has been defined so
    // that no pattern ever reads a key entry that was never written.
    // ------------------------------------------------------------------
    logic [CODE_W-1:0]   gen_codes [NUM_PATTERNS][MAX_KEYS];
    logic [MAX_KEYS-1:0] gen_known [NUM_PATTERNS];
    int                  gen_len   [NUM_PATTERNS];
    logic                gen_kind  [NUM_PATTERNS];
    int                  gen_next  [NUM_PATTERNS];
    int                  stim_count = 0;
    logic                drain_next = 1'b0;

    function automatic logic [MAP_W-1:0] key_mask(input int code);
        return MAP_W'(1) << code;
    endfunction

    function automatic logic [MAP_W-1:0] full_map();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [MAP_W-1:0] sparse_map();
        return full_map() & full_map() & full_map();
    endfunction

    // every field random, so don't-care fields toggle too
    function automatic item_t rand_item();
        item_t it;
        it.mode        = 2'($urandom());
        it.slot        = SLOT_W'($urandom());
        it.pos         = POS_W'($urandom());
        it.code        = CODE_W'($urandom());
        it.kind        = 1'($urandom());
        it.len         = LEN_W'($urandom());
        it.win         = WIN_W'($urandom());
        it.held        = full_map();
        it.pressed     = full_map();
        it.drain_first = 1'b0;
        return it;
    endfunction

    task automatic push_item(input item_t it);
        it.drain_first = drain_next;
        drain_next = 1'b0;
        // ignored items do not count toward the item budget
        if (!(it.mode == MODE_UNUSED || (it.mode == MODE_HDR && it.len > MAX_KEYS)))
            stim_count++;
        queued_items.push_back(it);
    endtask

    task automatic push_key(input int s, input int pos, input int code);
        item_t it;
        it = rand_item();
        it.mode = MODE_KEY;
        it.slot = SLOT_W'(s);
        it.pos  = POS_W'(pos);
        it.code = CODE_W'(code);
        gen_codes[s][pos] = CODE_W'(code);
        gen_known[s][pos] = 1'b1;
        push_item(it);
    endtask

    task automatic push_hdr(input int s, input logic kind, input int len, input int win);
        item_t it;
        it = rand_item();
        it.mode = MODE_HDR;
        it.slot = SLOT_W'(s);
        it.kind = kind;
        it.len  = LEN_W'(len);
        it.win  = WIN_W'(win);
        if (len <= MAX_KEYS) begin
            gen_len[s]  = len;
            gen_kind[s] = (len == 0) ? KIND_CHORD : kind;
            gen_next[s] = 0;
        end
        push_item(it);
    endtask

    task automatic push_frame(input logic [MAP_W-1:0] held, input logic [MAP_W-1:0] pressed);
        item_t it;
        it = rand_item();
        it.mode    = MODE_FRAME;
        it.held    = held;
        it.pressed = pressed;
        push_item(it);
    endtask

    task automatic push_unused();
        item_t it;
        it = rand_item();
        it.mode = MODE_UNUSED;
        push_item(it);
    endtask

    function automatic int known_prefix(input int s);
        int m;
        m = 0;
        while (m < MAX_KEYS && gen_known[s][m]) m++;
        return m;
    endfunction

    function automatic int pick_window();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 0;                     // default window
        if (r < 7) return $urandom_range(1, 4);  // tight, times out easily
        if (r == 7) return 16'hFFFF;
        if (r == 8) return $urandom_range(5, 40);
        return $urandom_range(0, 16'hFFFF);
    endfunction

    // Frames for slot s: chords mostly held, combos mostly in order, at times quiet after.
    task automatic push_slot_frame(input int s);
        logic [MAP_W-1:0] chord_keys, held, pressed, noise;
        int n, r, pick, k;
        n = gen_len[s];
        noise = sparse_map();
        r = $urandom_range(0, 9);
        if (n == 0) begin
            push_frame(noise, sparse_map());
        end else if (gen_kind[s] == KIND_CHORD) begin
            chord_keys = '0;
            for (k = 0; k < n; k++) chord_keys = chord_keys | key_mask(gen_codes[s][k]);
            pick = $urandom_range(0, n - 1);
            held = noise | chord_keys;
            if (r < 2) held = held & ~key_mask(gen_codes[s][pick]);  // one key let go
            else if (r == 9) held = noise;                          // chord released
            if (r < 6) pressed = key_mask(gen_codes[s][pick]) | (noise & sparse_map());
            else pressed = noise & sparse_map();
            push_frame(held, pressed);
        end else begin
            if (r < 7) begin
                pressed = key_mask(gen_codes[s][gen_next[s]]);
                gen_next[s] = (gen_next[s] + 1) % n;
            end else if (r == 7) begin
                // a member key out of turn
                pressed = key_mask(gen_codes[s][$urandom_range(0, n - 1)]);
                gen_next[s] = 0;
            end else begin
                pressed = '0;
            end
            push_frame(noise, pressed);
            // quiet frames to run past the window
            if (r == 9) repeat ($urandom_range(1, 6)) push_frame(sparse_map(), '0);
        end
    endtask

    // Load a fresh pattern into slot s, then exercise it for a few frames.
    task automatic define_pattern(input int s);
        int n, k;
        logic kind;
        logic backwards;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, MAX_KEYS) : $urandom_range(1, 4);
        kind = 1'($urandom_range(0, 1));
        backwards = 1'($urandom_range(0, 1));
        for (k = 0; k < n; k++) begin
            if (backwards) push_key(s, n - 1 - k, $urandom_range(0, 63));
            else push_key(s, k, $urandom_range(0, 63));
        end
        push_hdr(s, kind, n, pick_window());
        repeat ($urandom_range(2, 7)) push_slot_frame(s);
    endtask

    task automatic push_noise();
        int r, s, m;
        r = $urandom_range(0, 9);
        s = $urandom_range(0, NUM_PATTERNS - 1);
        case (r)
            0, 1, 2: push_frame(full_map(), full_map());
            3:       push_unused();
            4:       push_hdr(s, 1'($urandom()), $urandom_range(MAX_KEYS + 1, 31),
                              $urandom_range(0, 16'hFFFF));
            5:       push_hdr(s, 1'($urandom()), 0, $urandom_range(0, 16'hFFFF));
            6:       push_key(s, $urandom_range(0, MAX_KEYS - 1), $urandom_range(0, 63));
            7: begin
                // redefine over keys already loaded
                m = known_prefix(s);
                if (m > 0) push_hdr(s, 1'($urandom()), $urandom_range(1, m), pick_window());
                else push_frame(sparse_map(), sparse_map());
            end
            default: push_frame(sparse_map(), sparse_map());
        endcase
    endtask

    // ------------------------------------------------------------------
    // Main sequence: fill the item queue, reset, wait for the drain, judge
    // ------------------------------------------------------------------
    initial begin
        int s, r, random_base;
        for (s = 0; s < NUM_PATTERNS; s++) begin
            pat_kind[s]    = KIND_CHORD;
            pat_len[s]     = '0;
            pat_window[s]  = '0;
            chord_prev[s]  = 1'b0;
            chord_on[s]    = 1'b0;
            combo_step[s]  = '0;
            combo_stamp[s] = '0;
            gen_known[s]   = '0;
            gen_len[s]     = 0;
            gen_kind[s]    = KIND_CHORD;
            gen_next[s]    = 0;
        end

        // --- directed part ---
        // all slots empty, bitmaps at both extremes
        push_frame('1, '1);
        push_frame('0, '0);
        // chord on the lowest and highest key codes; chord ignores the window
        push_key(0, 0, 0);
        push_key(0, 1, 63);
        push_hdr(0, KIND_CHORD, 2, 16'hFFFF);
        push_frame(key_mask(0) | key_mask(63), key_mask(63));  // edge: fires
        push_frame(key_mask(0) | key_mask(63), '0);            // still held, no edge
        push_frame(key_mask(0), key_mask(0));                  // one key up
        // two-key combo with the default window, top position written too
        push_key(7, 0, 5);
        push_key(7, 1, 9);
        push_key(7, MAX_KEYS - 1, 42);
        drain_next = 1'b1;
        push_hdr(7, KIND_COMBO, 2, 0);
        push_frame('0, key_mask(5));   // first key
        push_frame('0, key_mask(9));   // completes
        push_frame('0, key_mask(9));   // wrong key while the first is expected
        push_frame('0, key_mask(5));
        // window of one frame: second quiet frame times out
        push_hdr(7, KIND_COMBO, 2, 1);
        push_frame('0, key_mask(5));
        push_frame('0, '0);
        push_frame('0, '0);
        // too long (ignored), unused mode, then emptying the slot
        push_hdr(7, KIND_COMBO, MAX_KEYS + 1, 3);
        push_unused();
        push_hdr(7, KIND_CHORD, 0, 16'h1234);
        push_frame('1, '1);

        // --- random part ---
        random_base = stim_count;
        while (stim_count - random_base < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            s = $urandom_range(0, NUM_PATTERNS - 1);
            if (r < 30) define_pattern(s);
            else if (r < 75) repeat ($urandom_range(1, 6)) push_slot_frame(s);
            else if (r < 93) push_noise();
            else drain_next = 1'b1;
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (!(queued_items.size() == 0 && !s_valid && pending_reports.size() == 0)
               && quiet_cycles < QUIET_LIMIT)
            @(posedge aclk);
        if (quiet_cycles < QUIET_LIMIT) repeat (TAIL_CYCLES) @(posedge aclk);

        if (quiet_cycles >= QUIET_LIMIT)
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        if (pending_reports.size() != 0)
            report_mismatch("reports never delivered", pending_reports.size(), 0);
        if (quiet_cycles < QUIET_LIMIT && mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
